// File: design/wspm_pkg.sv
`timescale 1ns / 1ps

package wspm_pkg;

   localparam int SLOTS_DEFAULT = 8;

   localparam int OP_W    = 3;
   localparam int IDX_W   = 3;
   localparam int STATE_W = 3;
   localparam int SEQ_W   = 8;
   localparam int STAMP_W = 32;

   localparam logic [STATE_W-1:0] ST_FREE    = 3'd0;
   localparam logic [STATE_W-1:0] ST_PENDING = 3'd1;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC       = 3'd0,
      OP_FREE        = 3'd1,
      OP_TAKE_OLDEST = 3'd2,
      OP_FIND_SEQ    = 3'd3,
      OP_SET_STATE   = 3'd4,
      OP_SET_SEQ     = 3'd5
   } op_type;

   typedef struct packed {
      logic [STATE_W-1:0] state;
      logic [STAMP_W-1:0] stamp;
      logic [SEQ_W-1:0]   seq;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   // controller -> datapath
   typedef struct packed {
      logic load;    // latch request, clear pick
      logic issue;   // read next slot
      logic commit;  // write back, register response
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;
   } ctl_status_type;

endpackage

// File: design/wspm_ram.sv
`timescale 1ns / 1ps

module wspm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/wspm_ctrl.sv
`timescale 1ns / 1ps

module wspm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_valid,
   output wspm_pkg::ctl_cmd_type    cmd,
   input  wspm_pkg::ctl_status_type status
);

   import wspm_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      DRAIN,
      COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      accept;

   // a new beat may enter during write-back; its reads start after the write
   assign busy   = !(state_ff == IDLE || state_ff == COMMIT);
   assign accept = start && !busy;

   always_comb begin
      cmd.load   = accept;
      cmd.issue  = (state_ff == SCAN);
      cmd.commit = (state_ff == COMMIT);
      state_in   = state_ff;
      case (state_ff)
         IDLE: begin
            if (accept) state_in = SCAN;
         end
         SCAN: begin
            if (status.scan_last) state_in = DRAIN;
         end
         DRAIN: begin
            state_in = COMMIT;
         end
         COMMIT: begin
            state_in = accept ? SCAN : IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == COMMIT);
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_enters_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == SCAN)
      else $error("accepted beat did not start a scan");

   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == COMMIT))
      else $error("response strobe without write-back");

   a_drain_to_commit: assert property (@(posedge clock) disable iff (reset)
      state_ff == DRAIN |=> state_ff == COMMIT)
      else $error("drain not followed by write-back");

endmodule

// File: design/wspm_datapath.sv
`timescale 1ns / 1ps

module wspm_datapath #(
   parameter int SLOTS = wspm_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wspm_pkg::ctl_cmd_type          cmd,
   output wspm_pkg::ctl_status_type       status,
   input  logic [wspm_pkg::OP_W-1:0]      req_operation,
   input  logic [wspm_pkg::IDX_W-1:0]     req_slot_index,
   input  logic [wspm_pkg::STATE_W-1:0]   req_state_code,
   input  logic [wspm_pkg::SEQ_W-1:0]     req_seq_value,
   input  logic [wspm_pkg::IDX_W-1:0]     req_skip_index,
   input  logic                          req_skip_valid,
   input  logic [wspm_pkg::STAMP_W-1:0]   req_current_tick,
   output logic                          rsp_found,
   output logic [wspm_pkg::IDX_W-1:0]     rsp_result_index
);

   import wspm_pkg::*;

   localparam int CW = $clog2(SLOTS);
   localparam int IW = (CW > IDX_W) ? CW : IDX_W;

   logic [OP_W-1:0]    op_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [STATE_W-1:0] code_ff;
   logic [SEQ_W-1:0]   seq_ff;
   logic [IDX_W-1:0]   skip_ff;
   logic               skip_on_ff;
   logic [STAMP_W-1:0] tick_ff;

   logic [CW-1:0]      cnt_ff;
   logic               eval_en_ff;
   logic [CW-1:0]      eval_idx_ff;
   logic               vld_q_ff;
   logic [SLOTS-1:0]   valid_ff;

   logic               hit_ff;
   logic [CW-1:0]      pick_idx_ff;
   slot_entry_type     pick_entry_ff;

   logic               rsp_found_ff;
   logic [IDX_W-1:0]   rsp_index_ff;

   logic [ENTRY_W-1:0] rd_data;
   slot_entry_type     entry_q;
   slot_entry_type     wr_entry;
   logic               wr_en;
   logic               take_it;
   logic               writes;
   logic               reports;
   logic [IW-1:0]      eval_w;
   logic [IW-1:0]      pick_w;

   assign status.scan_last = (cnt_ff == CW'(SLOTS - 1));

   // entries never written read as the reset value
   assign entry_q = vld_q_ff ? slot_entry_type'(rd_data) : '0;
   assign eval_w  = IW'(eval_idx_ff);
   assign pick_w  = IW'(pick_idx_ff);

   always_comb begin
      take_it  = 1'b0;
      writes   = 1'b0;
      reports  = 1'b0;
      wr_entry = pick_entry_ff;
      case (op_ff)
         OP_ALLOC: begin
            take_it        = !hit_ff && entry_q.state == ST_FREE;
            writes         = 1'b1;
            reports        = 1'b1;
            wr_entry.state = ST_PENDING;
         end
         OP_FREE: begin
            take_it  = eval_w == IW'(idx_ff);
            writes   = 1'b1;
            wr_entry = '0;
         end
         OP_TAKE_OLDEST: begin
            take_it        = entry_q.state == code_ff &&
                             (!hit_ff || entry_q.stamp < pick_entry_ff.stamp);
            writes         = 1'b1;
            reports        = 1'b1;
            wr_entry.stamp = tick_ff;
         end
         OP_FIND_SEQ: begin
            take_it = !hit_ff && !(skip_on_ff && eval_w == IW'(skip_ff)) &&
                      entry_q.state != ST_FREE && entry_q.seq == seq_ff;
            reports = 1'b1;
         end
         OP_SET_STATE: begin
            take_it        = eval_w == IW'(idx_ff);
            writes         = 1'b1;
            wr_entry.state = code_ff;
         end
         OP_SET_SEQ: begin
            take_it      = eval_w == IW'(idx_ff);
            writes       = 1'b1;
            wr_entry.seq = seq_ff;
         end
         default: begin
            take_it = 1'b0;
         end
      endcase
   end

   assign wr_en = cmd.commit && hit_ff && writes;

   wspm_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(pick_idx_ff),
      .wr_data(wr_entry),
      .rd_en  (cmd.issue),
      .rd_addr(cnt_ff),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         eval_en_ff <= 1'b0;
         hit_ff     <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         eval_en_ff <= cmd.issue;
         if (wr_en) begin
            valid_ff[pick_idx_ff] <= 1'b1;
         end
         if (cmd.load) begin
            cnt_ff <= '0;
         end else if (cmd.issue && !status.scan_last) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
         if (cmd.load) begin
            hit_ff <= 1'b0;
         end else if (eval_en_ff && take_it) begin
            hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         eval_idx_ff <= cnt_ff;
         vld_q_ff    <= valid_ff[cnt_ff];
      end
      if (cmd.load) begin
         op_ff       <= req_operation;
         idx_ff      <= req_slot_index;
         code_ff     <= req_state_code;
         seq_ff      <= req_seq_value;
         skip_ff     <= req_skip_index;
         skip_on_ff  <= req_skip_valid;
         tick_ff     <= req_current_tick;
         pick_idx_ff <= '0;
      end else if (eval_en_ff && take_it) begin
         pick_idx_ff   <= eval_idx_ff;
         pick_entry_ff <= entry_q;
      end
      if (cmd.commit) begin
         rsp_found_ff <= hit_ff && reports;
         rsp_index_ff <= (hit_ff && reports) ? pick_w[IDX_W-1:0] : '0;
      end
   end

   assign rsp_found        = rsp_found_ff;
   assign rsp_result_index = rsp_index_ff;

   a_write_only_commit: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> cmd.commit && hit_ff)
      else $error("slot write outside write-back");

   a_eval_follows_read: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |=> eval_en_ff)
      else $error("read data not evaluated");

   a_load_clears_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !hit_ff)
      else $error("pick not cleared for new beat");

endmodule

// File: design/work_slot_pool_manager_top.sv
`timescale 1ns / 1ps

// Channel   Ports              Handshake
// request   start, busy, req_*  beat taken when start && !busy
// response  rsp_valid, rsp_*    one-cycle strobe, always taken
//
// Every operation walks the slot RAM read port one entry per cycle, then a
// drain state takes the last registered read and a write-back state writes
// back; the next accept can come during write-back. The response strobe is
// registered and follows in the cycle after write-back. Reset is synchronous;
// per-slot valid flops are cleared so every slot reads as free with zero stamp
// and sequence, with no clearing pass. The response side cannot stall.

module work_slot_pool_manager_top #(
   parameter int SLOTS = wspm_pkg::SLOTS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [wspm_pkg::OP_W-1:0]    req_operation,
   input  logic [wspm_pkg::IDX_W-1:0]   req_slot_index,
   input  logic [wspm_pkg::STATE_W-1:0] req_state_code,
   input  logic [wspm_pkg::SEQ_W-1:0]   req_seq_value,
   input  logic [wspm_pkg::IDX_W-1:0]   req_skip_index,
   input  logic                        req_skip_valid,
   input  logic [wspm_pkg::STAMP_W-1:0] req_current_tick,
   output logic                        rsp_valid,
   output logic                        rsp_found,
   output logic [wspm_pkg::IDX_W-1:0]   rsp_result_index
);

   import wspm_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   wspm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .cmd      (cmd),
      .status   (status)
   );

   wspm_datapath #(
      .SLOTS(SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_operation),
      .req_slot_index  (req_slot_index),
      .req_state_code  (req_state_code),
      .req_seq_value   (req_seq_value),
      .req_skip_index  (req_skip_index),
      .req_skip_valid  (req_skip_valid),
      .req_current_tick(req_current_tick),
      .rsp_found       (rsp_found),
      .rsp_result_index(rsp_result_index)
   );

endmodule

// File: dv/slot_pool_checker.sv
`timescale 1ns / 1ps

module slot_pool_checker #(
   parameter int SLOTS = wspm_pkg::SLOTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [wspm_pkg::OP_W-1:0]    req_operation,
   input  logic [wspm_pkg::IDX_W-1:0]   req_slot_index,
   input  logic [wspm_pkg::STATE_W-1:0] req_state_code,
   input  logic [wspm_pkg::SEQ_W-1:0]   req_seq_value,
   input  logic [wspm_pkg::IDX_W-1:0]   req_skip_index,
   input  logic                         req_skip_valid,
   input  logic [wspm_pkg::STAMP_W-1:0] req_current_tick,
   input  logic                         rsp_valid,
   input  logic                         rsp_found,
   input  logic [wspm_pkg::IDX_W-1:0]   rsp_result_index,
   output int                           mismatch_count,
   output int                           outstanding,
   output int                           checked_count,
   output int                           hit_count
);
   import wspm_pkg::*;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] index;
   } slot_pick_type;

   slot_pick_type      expected_picks [$];

   logic [STATE_W-1:0] pool_state [SLOTS];
   logic [STAMP_W-1:0] pool_stamp [SLOTS];
   logic [SEQ_W-1:0]   pool_seq   [SLOTS];

   // Applies one request beat to the shadow pool and returns the slot it picks.
   function automatic slot_pick_type predict_slot_pick(
      input logic [OP_W-1:0]    op,
      input logic [IDX_W-1:0]   idx,
      input logic [STATE_W-1:0] code,
      input logic [SEQ_W-1:0]   seq,
      input logic [IDX_W-1:0]   skip,
      input logic               skip_on,
      input logic [STAMP_W-1:0] tick
   );
      slot_pick_type pick;
      int            best;
      pick = '0;
      best = 0;
      case (op)
         OP_ALLOC: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!pick.found && pool_state[i] == ST_FREE) begin
                  pool_state[i] = ST_PENDING;
                  pick.found = 1'b1;
                  best = i;
               end
            end
         end
         OP_FREE: begin
            if (idx < SLOTS) begin
               pool_state[idx] = ST_FREE;
               pool_stamp[idx] = '0;
               pool_seq[idx]   = '0;
            end
         end
         OP_TAKE_OLDEST: begin
            // strict compare keeps the lowest index on equal stamps
            for (int i = 0; i < SLOTS; i++) begin
               if (pool_state[i] == code &&
                   (!pick.found || pool_stamp[i] < pool_stamp[best])) begin
                  pick.found = 1'b1;
                  best = i;
               end
            end
            if (pick.found)
               pool_stamp[best] = tick;
         end
         OP_FIND_SEQ: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!pick.found && !(skip_on && i == skip) &&
                   pool_state[i] != ST_FREE && pool_seq[i] == seq) begin
                  pick.found = 1'b1;
                  best = i;
               end
            end
         end
         OP_SET_STATE: begin
            if (idx < SLOTS)
               pool_state[idx] = code;
         end
         OP_SET_SEQ: begin
            if (idx < SLOTS)
               pool_seq[idx] = seq;
         end
         default: ;
      endcase
      pick.index = pick.found ? IDX_W'(best) : '0;
      return pick;
   endfunction

   always @(posedge clock) begin
      slot_pick_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            pool_state[i] = ST_FREE;
            pool_stamp[i] = '0;
            pool_seq[i]   = '0;
         end
         expected_picks.delete();
         mismatch_count = 0;
         checked_count  = 0;
         hit_count      = 0;
      end else begin
         // a response always belongs to a beat taken at an earlier edge
         if (rsp_valid) begin
            if (expected_picks.size() == 0) begin
               $error("unexpected response beat: found=%0d result_index=%0d",
                      rsp_found, rsp_result_index);
               mismatch_count++;
            end else begin
               want = expected_picks.pop_front();
               checked_count++;
               if (want.found)
                  hit_count++;
               if (rsp_found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_found);
                  mismatch_count++;
               end
               if (rsp_result_index !== want.index) begin
                  $error("result_index: expected %0d, got %0d",
                         want.index, rsp_result_index);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy)
            expected_picks.push_back(predict_slot_pick(req_operation, req_slot_index,
               req_state_code, req_seq_value, req_skip_index, req_skip_valid,
               req_current_tick));
      end
      outstanding = expected_picks.size();
   end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import wspm_pkg::*;

   localparam int SLOTS = SLOTS_DEFAULT;
   localparam int RANDOM_BEATS = 1900;
   localparam int STALL_LIMIT = 400;

   // codes the block must ignore
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [OP_W-1:0]      req_operation = '0;
   logic [IDX_W-1:0]     req_slot_index = '0;
   logic [STATE_W-1:0]   req_state_code = '0;
   logic [SEQ_W-1:0]     req_seq_value = '0;
   logic [IDX_W-1:0]     req_skip_index = '0;
   logic                 req_skip_valid = 1'b0;
   logic [STAMP_W-1:0]   req_current_tick = '0;
   logic                 rsp_valid;
   logic                 rsp_found;
   logic [IDX_W-1:0]     rsp_result_index;

   int mismatches;
   int outstanding;
   int checked;
   int hits;
   int beats_sent = 0;
   int quiet_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   work_slot_pool_manager_top #(.SLOTS(SLOTS)) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_slot_index   (req_slot_index),
      .req_state_code   (req_state_code),
      .req_seq_value    (req_seq_value),
      .req_skip_index   (req_skip_index),
      .req_skip_valid   (req_skip_valid),
      .req_current_tick (req_current_tick),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_result_index (rsp_result_index)
   );

   slot_pool_checker #(.SLOTS(SLOTS)) pool_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_slot_index   (req_slot_index),
      .req_state_code   (req_state_code),
      .req_seq_value    (req_seq_value),
      .req_skip_index   (req_skip_index),
      .req_skip_valid   (req_skip_valid),
      .req_current_tick (req_current_tick),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_result_index (rsp_result_index),
      .mismatch_count   (mismatches),
      .outstanding      (outstanding),
      .checked_count    (checked),
      .hit_count        (hits)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
         $display("tb_top failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Holds the beat until taken, then drops start and idles for the given gap.
   // With gap 0 start stays high so the next beat can go out back to back.
   task automatic send_beat(
      input logic [OP_W-1:0]    op,
      input logic [IDX_W-1:0]   idx,
      input logic [STATE_W-1:0] code,
      input logic [SEQ_W-1:0]   seq,
      input logic [IDX_W-1:0]   skip,
      input logic               skip_on,
      input logic [STAMP_W-1:0] tick,
      input int                 gap
   );
      req_operation    <= op;
      req_slot_index   <= idx;
      req_state_code   <= code;
      req_seq_value    <= seq;
      req_skip_index   <= skip;
      req_skip_valid   <= skip_on;
      req_current_tick <= tick;
      start            <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      beats_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // bias 0 fills the pool, 2 drains it, 1 is balanced
   function automatic logic [OP_W-1:0] pick_op(input int bias);
      int r;
      int alloc_w;
      int free_w;
      alloc_w = (bias == 0) ? 40 : (bias == 1) ? 20 : 8;
      free_w  = (bias == 0) ? 5 : (bias == 1) ? 15 : 35;
      r = $urandom_range(0, 99);
      if (r < alloc_w)
         return OP_ALLOC;
      if (r < alloc_w + free_w)
         return OP_FREE;
      r = $urandom_range(0, 99);
      if (r < 30) return OP_TAKE_OLDEST;
      if (r < 60) return OP_FIND_SEQ;
      if (r < 75) return OP_SET_STATE;
      if (r < 92) return OP_SET_SEQ;
      if (r < 96) return OP_SPARE_6;
      return OP_SPARE_7;
   endfunction

   // small pool of sequence numbers so find_seq hits often
   function automatic logic [SEQ_W-1:0] pick_seq();
      if ($urandom_range(0, 4) == 0)
         return SEQ_W'($urandom);
      return SEQ_W'($urandom_range(0, 3));
   endfunction

   // small ticks give stamp ties
   function automatic logic [STAMP_W-1:0] pick_tick();
      if ($urandom_range(0, 1) == 0)
         return STAMP_W'($urandom);
      return STAMP_W'($urandom_range(0, 15));
   endfunction

   initial begin
      int                 bias;
      int                 gap;
      logic               calm;
      logic [OP_W-1:0]    op;
      logic [STATE_W-1:0] code;
      bias = 1;
      calm = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty pool: no sequence match, then take_oldest on free slots
      send_beat(OP_FIND_SEQ, 0, 0, 8'h00, 0, 1'b0, 0, $urandom_range(0, 8));
      send_beat(OP_TAKE_OLDEST, 0, ST_FREE, 0, 0, 1'b0, 32'hFFFF_FFFF, 0);
      // fill every slot, then one alloc with nothing free
      for (int i = 0; i <= SLOTS; i++)
         send_beat(OP_ALLOC, 0, 0, 0, 0, 1'b0, 0, $urandom_range(0, 8));
      send_beat(OP_SET_SEQ, 3, 0, 8'hFF, 0, 1'b0, 0, 0);
      send_beat(OP_SET_SEQ, 5, 0, 8'hFF, 0, 1'b0, 0, $urandom_range(0, 8));
      send_beat(OP_FIND_SEQ, 0, 0, 8'hFF, 0, 1'b0, 0, 0);
      send_beat(OP_FIND_SEQ, 0, 0, 8'hFF, 3, 1'b1, 0, 0);
      send_beat(OP_FIND_SEQ, 0, 0, 8'hFF, 7, 1'b1, 0, $urandom_range(0, 8));
      send_beat(OP_SET_STATE, 2, 3'd7, 0, 0, 1'b0, 0, 0);
      send_beat(OP_TAKE_OLDEST, 0, 3'd7, 0, 0, 1'b0, 32'hFFFF_FFFF, 0);
      send_beat(OP_TAKE_OLDEST, 0, ST_PENDING, 0, 0, 1'b0, 32'h0, $urandom_range(0, 8));
      // setting state free keeps stamp and seq
      send_beat(OP_SET_STATE, 4, ST_FREE, 0, 0, 1'b0, 0, 0);
      send_beat(OP_FIND_SEQ, 0, 0, 8'h00, 0, 1'b0, 0, 0);
      send_beat(OP_FREE, 7, 0, 0, 0, 1'b0, 0, $urandom_range(0, 8));
      send_beat(OP_SPARE_6, 7, 3'd7, 8'hFF, 7, 1'b1, 32'hFFFF_FFFF, 0);
      send_beat(OP_SPARE_7, 0, 0, 0, 0, 1'b0, 0, 0);
      send_beat(OP_ALLOC, 0, 0, 0, 0, 1'b0, 0, $urandom_range(0, 8));

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 100 == 0) begin
            bias = $urandom_range(0, 2);
            calm = ($urandom_range(0, 3) == 0);
         end
         op = pick_op(bias);
         if (op == OP_TAKE_OLDEST && $urandom_range(0, 1) == 1)
            code = ST_PENDING;
         else
            code = STATE_W'($urandom_range(0, 7));
         gap = calm ? 0 : $urandom_range(0, 8);
         send_beat(op, IDX_W'($urandom_range(0, 7)), code, pick_seq(),
                   IDX_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   pick_tick(), gap);
      end
      start <= 1'b0;

      while (outstanding != 0)
         @(posedge clock);
      repeat (4 * SLOTS) @(posedge clock);

      $display("%0d request beats sent, %0d responses checked, %0d picked a slot",
               beats_sent, checked, hits);
      $display("all six operations, both unused codes, full and empty pool covered");
      if (mismatches == 0 && outstanding == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

// File: files.f
design/wspm_pkg.sv
design/wspm_ram.sv
design/wspm_ctrl.sv
design/wspm_datapath.sv
design/work_slot_pool_manager_top.sv
dv/slot_pool_checker.sv
dv/tb_top.sv
